FILE: sv/frx_pkg.sv
// Shared types and constants of the frame stream receive parser.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package frx_pkg;

  // Header layout and frame checks
  localparam logic [4:0]  HDR_BYTES     = 5'd20;
  localparam logic [31:0] FLAG_SHMDATA  = 32'h8000_0000;
  localparam logic [31:0] FLAG_SHMREL   = 32'h4000_0000;
  localparam logic [31:0] FLAG_SHMREV   = 32'hC000_0000;
  localparam logic [31:0] FLAG_SHMMASK  = 32'hFF00_0000;
  localparam logic [31:0] FLAG_SEEKMASK = 32'h0000_00FF;
  localparam logic [31:0] SEEK_MAX      = 32'd3;
  localparam logic [31:0] SHM_LEN       = 32'd16;
  localparam logic [31:0] CHAN_PACKET   = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_LEN_RESET = 32'd16777216;

  typedef enum logic [3:0] {
    EV_ABSORBED = 4'd0,
    EV_RELEASE  = 4'd1,
    EV_REVOKE   = 4'd2,
    EV_PACKET   = 4'd3,
    EV_MEMBLOCK = 4'd4,
    EV_PAYLOAD  = 4'd5,
    EV_SHM_REF  = 4'd6,
    EV_ERROR    = 4'd7,
    EV_DROPPED  = 4'd8
  } frx_event_t;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_SHM_DISABLED = 3'd1,
    ERR_BAD_SIZE     = 3'd2,
    ERR_PACKET_FLAGS = 3'd3,
    ERR_SEEK_RANGE   = 3'd4,
    ERR_SHM_LENGTH   = 3'd5,
    ERR_MEMBLK_FLAGS = 3'd6
  } frx_error_t;

  typedef enum logic [1:0] {
    KIND_PACKET   = 2'd0,
    KIND_MEMBLOCK = 2'd1,
    KIND_SHM      = 2'd2
  } frx_kind_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_SHM_ENABLED = 1'b0,
    CFG_MAX_LEN     = 1'b1
  } frx_cfg_idx_t;

  // One result transaction
  typedef struct packed {
    frx_event_t  event_res;
    frx_error_t  error_code;
    logic [31:0] channel;
    logic [63:0] offset;
    logic [1:0]  seek_sel;
    logic [31:0] frame_length;
    logic [31:0] block_tag;
    logic [31:0] shm_id;
    logic [31:0] shm_index;
    logic [7:0]  payload_byte;
    logic        frame_end;
  } frx_result_t;

endpackage

`default_nettype wire

FILE: sv/frx_front.sv
// Front end: accepts received bytes, gathers the header, classifies frames
// and forms one result per byte. Depends on frx_pkg.
`default_nettype none

module frx_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               take,
  input  wire logic [7:0]         data_byte,
  input  wire logic               shm_enabled,
  input  wire logic [31:0]        max_len,
  output frx_pkg::frx_result_t    res
);
  import frx_pkg::*;

  logic [4:0]  hdr_count_r, hdr_count_nxt;
  logic [31:0] hdr_r [5];
  logic [31:0] hdr_nxt [5];
  logic [31:0] pay_count_r, pay_count_nxt;
  frx_kind_t   kind_r, kind_nxt;
  logic [31:0] shm_r [4];
  logic [31:0] shm_nxt [4];
  logic        halted_r, halted_nxt;

  logic [2:0]  hw_idx;
  logic [1:0]  sw_idx;
  logic [31:0] flags;
  logic [31:0] pay_inc;
  logic        last;

  assign hw_idx  = hdr_count_r[4:2];
  assign sw_idx  = pay_count_r[3:2];
  assign flags   = {hdr_r[4][23:0], data_byte};
  assign pay_inc = pay_count_r + 32'd1;
  assign last    = pay_inc >= hdr_r[0];

  // Form the result and the next state for the byte at the input
  always_comb begin
    res           = '0;
    res.event_res = EV_ABSORBED;
    res.error_code = ERR_NONE;
    hdr_count_nxt = hdr_count_r;
    hdr_nxt       = hdr_r;
    pay_count_nxt = pay_count_r;
    kind_nxt      = kind_r;
    shm_nxt       = shm_r;
    halted_nxt    = halted_r;

    if (halted_r) begin
      res.event_res = EV_DROPPED;
    end else if (hdr_count_r < HDR_BYTES) begin
      hdr_nxt[hw_idx] = {hdr_r[hw_idx][23:0], data_byte};
      hdr_count_nxt   = hdr_count_r + 5'd1;
      if (hdr_count_r == HDR_BYTES - 5'd1) begin
        // Classify the complete header
        priority if (!shm_enabled && (flags & FLAG_SHMMASK) != 32'd0) begin
          halted_nxt     = 1'b1;
          res.event_res  = EV_ERROR;
          res.error_code = ERR_SHM_DISABLED;
        end else if (flags == FLAG_SHMREL || flags == FLAG_SHMREV) begin
          res.event_res    = (flags == FLAG_SHMREL) ? EV_RELEASE : EV_REVOKE;
          res.channel      = hdr_r[1];
          res.offset       = {hdr_r[2], hdr_r[3]};
          res.seek_sel     = flags[1:0];
          res.frame_length = hdr_r[0];
          res.block_tag    = hdr_r[2];
          res.frame_end    = 1'b1;
          hdr_count_nxt    = '0;
        end else if (hdr_r[0] == 32'd0 || hdr_r[0] > max_len) begin
          halted_nxt     = 1'b1;
          res.event_res  = EV_ERROR;
          res.error_code = ERR_BAD_SIZE;
        end else if (hdr_r[1] == CHAN_PACKET) begin
          pay_count_nxt = '0;
          if (flags != 32'd0) begin
            halted_nxt     = 1'b1;
            res.event_res  = EV_ERROR;
            res.error_code = ERR_PACKET_FLAGS;
          end else begin
            kind_nxt         = KIND_PACKET;
            res.event_res    = EV_PACKET;
            res.channel      = hdr_r[1];
            res.offset       = {hdr_r[2], hdr_r[3]};
            res.seek_sel     = flags[1:0];
            res.frame_length = hdr_r[0];
          end
        end else if ((flags & FLAG_SEEKMASK) > SEEK_MAX) begin
          pay_count_nxt  = '0;
          halted_nxt     = 1'b1;
          res.event_res  = EV_ERROR;
          res.error_code = ERR_SEEK_RANGE;
        end else if ((flags & FLAG_SHMMASK) == FLAG_SHMDATA) begin
          pay_count_nxt = '0;
          if (hdr_r[0] != SHM_LEN) begin
            halted_nxt     = 1'b1;
            res.event_res  = EV_ERROR;
            res.error_code = ERR_SHM_LENGTH;
          end else begin
            kind_nxt = KIND_SHM;
          end
        end else if ((flags & FLAG_SHMMASK) != 32'd0) begin
          pay_count_nxt  = '0;
          halted_nxt     = 1'b1;
          res.event_res  = EV_ERROR;
          res.error_code = ERR_MEMBLK_FLAGS;
        end else begin
          pay_count_nxt    = '0;
          kind_nxt         = KIND_MEMBLOCK;
          res.event_res    = EV_MEMBLOCK;
          res.channel      = hdr_r[1];
          res.offset       = {hdr_r[2], hdr_r[3]};
          res.seek_sel     = flags[1:0];
          res.frame_length = hdr_r[0];
        end
      end
    end else begin
      pay_count_nxt = pay_inc;
      if (kind_r == KIND_SHM) begin
        // Gather the reference words; report on the last byte
        shm_nxt[sw_idx] = {shm_r[sw_idx][23:0], data_byte};
        if (last) begin
          res.event_res    = EV_SHM_REF;
          res.channel      = hdr_r[1];
          res.offset       = {hdr_r[2], hdr_r[3]};
          res.seek_sel     = hdr_r[4][1:0];
          res.frame_length = shm_nxt[3];
          res.block_tag    = shm_nxt[0];
          res.shm_id       = shm_nxt[1];
          res.shm_index    = shm_nxt[2];
          res.frame_end    = 1'b1;
          hdr_count_nxt    = '0;
        end
      end else begin
        // Pass the payload byte through
        res.event_res    = EV_PAYLOAD;
        res.channel      = hdr_r[1];
        res.offset       = {hdr_r[2], hdr_r[3]};
        res.seek_sel     = hdr_r[4][1:0];
        res.frame_length = hdr_r[0];
        res.payload_byte = data_byte;
        res.frame_end    = last;
        if (kind_r == KIND_MEMBLOCK) begin
          hdr_nxt[2] = '0;
          hdr_nxt[3] = '0;
          hdr_nxt[4] = '0;
        end
        if (last) begin
          hdr_count_nxt = '0;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_count_r <= '0;
      pay_count_r <= '0;
      kind_r      <= KIND_PACKET;
      halted_r    <= 1'b0;
    end else if (take) begin
      hdr_count_r <= hdr_count_nxt;
      pay_count_r <= pay_count_nxt;
      kind_r      <= kind_nxt;
      halted_r    <= halted_nxt;
    end
  end

  // Header and reference words are always written before they are read
  always_ff @(posedge clk) begin
    if (take) begin
      hdr_r <= hdr_nxt;
      shm_r <= shm_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/frx_queue.sv
// Two-entry result queue between the front end and the output stage.
// Depends on frx_pkg.
`default_nettype none

module frx_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire frx_pkg::frx_result_t push_data,
  output logic                    not_full,
  input  wire logic               pop,
  output logic                    not_empty,
  output frx_pkg::frx_result_t    head
);
  import frx_pkg::*;

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  frx_result_t     mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;

  assign not_full  = count_r != CntW'(Depth);
  assign not_empty = count_r != '0;
  assign head      = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      priority if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push)     count_r <= count_r - 1'b1;
      else                       count_r <= count_r;
    end
  end

  // Store transactions
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

FILE: sv/frx_back.sv
// Output stage: takes results from the queue and holds them on the result
// channel until the consumer accepts. Depends on frx_pkg.
`default_nettype none

module frx_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire frx_pkg::frx_result_t q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output frx_pkg::frx_result_t    out_res
);
  import frx_pkg::*;

  logic        valid_r;
  frx_result_t data_r;

  // Load when the register is free or being drained this cycle
  assign q_pop     = q_valid && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_res   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_ready) begin
      valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) data_r <= q_head;
  end

endmodule

`default_nettype wire

FILE: sv/frame_stream_receive_parser.sv
// Top level of the frame stream receive parser: configuration registers,
// front end, result queue and output stage. Depends on frx_pkg and submodules.
//
// Takes one received byte per clock and returns exactly one result per byte,
// in order. A byte's result is written into the queue as the byte is accepted
// and then loaded into the output register, which holds it on the out_ channel
// until taken. The front end decides each byte's result in the cycle it is
// accepted, so the sustained rate is one byte per cycle; the input stalls only
// when results back up: with out_ready held low, the output register and the
// two-entry queue hold three results before in_ready drops. Each frame starts
// with a 20-byte big-endian header (length, channel, offset high, offset low,
// flags); after the last header byte the frame is classified and checked,
// payload bytes are passed through with frame_end on the last, and the 16 bytes
// of a shared-memory reference come out as one result. Any error halts the
// parser, which then reports every byte as dropped until reset. Configuration
// is to be written only while no transaction is in flight; the block does not
// enforce this, the user must. No clearing pass is needed after reset.
`default_nettype none

module frame_stream_receive_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Configuration write channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_data,
  // Received bytes
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_data_byte,
  // Results
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [3:0]              out_event_res,
  output logic [2:0]              out_error_code,
  output logic [31:0]             out_channel,
  output logic signed [63:0]      out_offset,
  output logic [1:0]              out_seek_sel,
  output logic [31:0]             out_frame_length,
  output logic [31:0]             out_block_tag,
  output logic [31:0]             out_shm_id,
  output logic [31:0]             out_shm_index,
  output logic [7:0]              out_payload_byte,
  output logic                    out_frame_end
);
  import frx_pkg::*;

  logic        shm_enabled_r;
  logic [31:0] max_len_r;
  logic        take;
  frx_result_t front_res;
  logic        q_not_full, q_not_empty, q_pop;
  frx_result_t q_head;
  frx_result_t out_res;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shm_enabled_r <= 1'b0;
      max_len_r     <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (frx_cfg_idx_t'(cfg_index))
        CFG_SHM_ENABLED: shm_enabled_r <= cfg_data[0];
        CFG_MAX_LEN:     max_len_r     <= cfg_data;
      endcase
    end
  end

  assign in_ready = q_not_full;
  assign take     = in_valid && in_ready;

  frx_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .data_byte   (in_data_byte),
    .shm_enabled (shm_enabled_r),
    .max_len     (max_len_r),
    .res         (front_res)
  );

  frx_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_data (front_res),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  frx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // Unpack the result transaction onto the ports
  assign out_event_res    = out_res.event_res;
  assign out_error_code   = out_res.error_code;
  assign out_channel      = out_res.channel;
  assign out_offset       = $signed(out_res.offset);
  assign out_seek_sel     = out_res.seek_sel;
  assign out_frame_length = out_res.frame_length;
  assign out_block_tag    = out_res.block_tag;
  assign out_shm_id       = out_res.shm_id;
  assign out_shm_index    = out_res.shm_index;
  assign out_payload_byte = out_res.payload_byte;
  assign out_frame_end    = out_res.frame_end;

  // An error result always names its cause, and only errors carry one
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_event_res == EV_ERROR) == (out_error_code != ERR_NONE)))
    else $error("error code does not match event");

  // Frame end only on events that close a frame
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |->
      (out_event_res == EV_RELEASE || out_event_res == EV_REVOKE ||
       out_event_res == EV_PAYLOAD || out_event_res == EV_SHM_REF))
    else $error("frame end on a non-closing event");

  // A payload byte is reported only with a payload event
  a_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res != EV_PAYLOAD) |-> (out_payload_byte == 8'd0))
    else $error("payload byte outside a payload event");

  // Input is throttled only while results back up
  a_backpress: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && q_not_empty))
    else $error("input stalled with room downstream");

endmodule

`default_nettype wire
